>>> sv/ycc_palette_color_generator_defines.svh
// ----------------------------------------------------------------------------
// ycc_palette_color_generator_defines
// Assertion macros used by the palette generator checker.
// ----------------------------------------------------------------------------
`ifndef YCC_PALETTE_COLOR_GENERATOR_DEFINES_SVH
`define YCC_PALETTE_COLOR_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define YCC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles, off during reset
`define YCC_ASSERT_DLY(lbl, clk, rst, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

// next-cycle implication, always on
`define YCC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ycc_pcg_pkg.sv
// ----------------------------------------------------------------------------
// ycc_pcg_pkg
// Types, constants and helper functions of the YCbCr palette color generator.
// ----------------------------------------------------------------------------
package ycc_pcg_pkg;

   localparam int IDX_W     = 8;
   localparam int LVL_W     = 9;
   localparam int CH_W      = 8;
   localparam int CSR_IDX_W = 2;
   localparam int IDX_SPAN  = 1 << IDX_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LUMA_LEVELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CR_LEVELS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CB_LEVELS   = 2'd2;

   localparam logic [LVL_W-1:0] LUMA_LEVELS_RST = 9'd8;
   localparam logic [LVL_W-1:0] CR_LEVELS_RST   = 9'd4;
   localparam logic [LVL_W-1:0] CB_LEVELS_RST   = 9'd4;

   // pipeline shape
   localparam int DIV_STEPS       = IDX_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int STAGES_PER_DIV  = DIV_STEPS / STEPS_PER_STAGE;
   localparam int SPLIT_DIVS      = 3;
   localparam int SPLIT_STAGES    = SPLIT_DIVS * STAGES_PER_DIV;
   localparam int LEVEL_STAGES    = STAGES_PER_DIV;
   localparam int TAIL_STAGES     = 5;
   localparam int RSP_LATENCY     = SPLIT_STAGES + LEVEL_STAGES + TAIL_STAGES;

   // lanes of the level divider and color channels
   localparam int NUM_LANES = 3;
   localparam int LANE_LUMA = 0;
   localparam int LANE_CR   = 1;
   localparam int LANE_CB   = 2;
   localparam int NUM_CH    = 3;
   localparam int CH_RED    = 0;
   localparam int CH_GREEN  = 1;
   localparam int CH_BLUE   = 2;

   // color math in thousandths
   localparam int MILLI_W = 18;
   localparam int PROD_W  = 21;
   localparam int RECIP_W = 19;
   localparam int QPROD_W = MILLI_W + RECIP_W;
   localparam int HALF_DIVIDEND = 128;

   localparam logic [LVL_W-1:0]          CENTER_LVL  = 9'd128;
   localparam logic [MILLI_W-1:0]        SCALE_MILLI = 18'd1000;
   localparam logic signed [PROD_W-1:0]  COEF_R_CB   = 21'sd1366;
   localparam logic signed [PROD_W-1:0]  COEF_G_CB   = 21'sd700;
   localparam logic signed [PROD_W-1:0]  COEF_G_CR   = 21'sd334;
   localparam logic signed [PROD_W-1:0]  COEF_B_CR   = 21'sd1732;
   localparam logic signed [PROD_W-1:0]  SAT_MILLI   = 21'sd255000;
   // ceil(2^28 / 1000): exact floor division for values below 2^18
   localparam logic [RECIP_W-1:0]        RECIP_1000  = 19'd268436;
   localparam int                        RECIP_SHIFT = 28;

   typedef logic [LVL_W-1:0] level_type;

   typedef struct packed {
      logic [LVL_W-1:0] rem;
      logic             qbit;
   } div_step_type;

   typedef struct packed {
      logic [IDX_W-1:0] shq;     // dividend bits out at the top, quotient bits in below
      logic [LVL_W-1:0] rem;
      logic [IDX_W-1:0] cb_num;
      logic [IDX_W-1:0] cr_num;
   } split_type;

   typedef struct packed {
      logic [LVL_W-1:0] rem;
      logic [IDX_W-1:0] quo;
   } lane_div_type;

   typedef struct packed {
      logic               full;
      logic [MILLI_W-1:0] val;
   } milli_sat_type;

   function automatic level_type eff_levels(input level_type v);
      return (v == '0) ? level_type'(1) : v;
   endfunction

   // one restoring division step; rem must be below divisor
   function automatic div_step_type div_step(input logic [LVL_W-1:0] rem,
                                             input logic din,
                                             input logic [LVL_W-1:0] divisor);
      logic [LVL_W:0] shifted;
      div_step_type   res;
      shifted = {rem, din};
      if (shifted >= {1'b0, divisor}) begin
         res.rem  = LVL_W'(shifted - {1'b0, divisor});
         res.qbit = 1'b1;
      end else begin
         res.rem  = shifted[LVL_W-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

   function automatic milli_sat_type sat_milli(input logic signed [PROD_W-1:0] sum);
      milli_sat_type res;
      res.full = 1'b0;
      res.val  = '0;
      if (!sum[PROD_W-1]) begin
         if (sum >= SAT_MILLI) begin
            res.full = 1'b1;
         end else begin
            res.val = sum[MILLI_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

>>> sv/ycc_palette_color_generator.sv
// ----------------------------------------------------------------------------
// ycc_palette_color_generator
// Takes one request per clock; the result strobe follows the accepted request
// through 12 index-split divider stages, 4 level divider stages and 5 color
// stages. busy is high only during reset.
// Synchronous reset flushes all requests in flight and loads the default
// level counts. The receiver cannot stall; csr_ready is low while a request
// is offered or in flight.
// ----------------------------------------------------------------------------
module ycc_palette_color_generator
   import ycc_pcg_pkg::*;
#(
   parameter int PALETTE_SIZE = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [IDX_W-1:0]     req_palette_index,
   output logic                 rsp_valid,
   output logic [CH_W-1:0]      rsp_red,
   output logic [CH_W-1:0]      rsp_green,
   output logic [CH_W-1:0]      rsp_blue,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LVL_W-1:0]     csr_wdata
);

   // configuration
   level_type luma_levels_ff, cr_levels_ff, cb_levels_ff;
   level_type lane_levels [NUM_LANES];

   logic [IDX_W-1:0] wrap_tab [IDX_SPAN];
   logic [IDX_W-1:0] half_tab [IDX_SPAN];

   // index split: cb, cr and luma divisions back to back
   logic [SPLIT_STAGES-1:0] split_vld_ff;
   split_type               split_ff  [SPLIT_STAGES];
   split_type               split_src [SPLIT_STAGES];
   split_type               split_in  [SPLIT_STAGES];

   // level value divisions, one lane per component
   logic [LEVEL_STAGES-1:0] lv_vld_ff;
   lane_div_type            lv_ff  [LEVEL_STAGES][NUM_LANES];
   lane_div_type            lv_src [LEVEL_STAGES][NUM_LANES];
   lane_div_type            lv_in  [LEVEL_STAGES][NUM_LANES];

   logic [TAIL_STAGES-1:0]  tail_vld_ff;

   logic [IDX_W-1:0]        lvl_val [NUM_LANES];
   logic [IDX_W-1:0]        e_luma_ff;
   logic signed [LVL_W-1:0] e_dcr_ff, e_dcb_ff;

   logic [MILLI_W-1:0]       m_luma_ff;
   logic signed [PROD_W-1:0] m_rcb_ff, m_gcb_ff, m_gcr_ff, m_bcr_ff;
   logic signed [PROD_W-1:0] ch_sum [NUM_CH];

   milli_sat_type           s_ff [NUM_CH];
   logic                    q_full_ff [NUM_CH];
   logic [CH_W-1:0]         q_val_ff  [NUM_CH];
   logic [CH_W-1:0]         q_val_in  [NUM_CH];
   logic [CH_W-1:0]         rsp_ch_ff [NUM_CH];

   logic                    req_accept;

   assign busy       = reset;
   assign req_accept = start && !busy;
   // a request entering at the same edge would see mixed level counts
   assign csr_ready  = !(req_accept || (|split_vld_ff) || (|lv_vld_ff) || (|tail_vld_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_levels_ff <= LUMA_LEVELS_RST;
         cr_levels_ff   <= CR_LEVELS_RST;
         cb_levels_ff   <= CB_LEVELS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LUMA_LEVELS: luma_levels_ff <= csr_wdata;
            REG_CR_LEVELS:   cr_levels_ff   <= csr_wdata;
            REG_CB_LEVELS:   cb_levels_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      lane_levels[LANE_LUMA] = eff_levels(luma_levels_ff);
      lane_levels[LANE_CR]   = eff_levels(cr_levels_ff);
      lane_levels[LANE_CB]   = eff_levels(cb_levels_ff);
   end

   // index wrap to the palette and the 256/(2R) term, both constant tables
   for (genvar gi = 0; gi < IDX_SPAN; gi++) begin : g_tab
      localparam int WRAP_VAL = gi % PALETTE_SIZE;
      localparam int HALF_VAL = HALF_DIVIDEND / ((gi == 0) ? 1 : gi);
      assign wrap_tab[gi] = IDX_W'(WRAP_VAL);
      assign half_tab[gi] = IDX_W'(HALF_VAL);
   end

   // ---------------- index split ----------------
   always_comb begin
      split_src[0] = '{shq: wrap_tab[req_palette_index], rem: '0, cb_num: '0, cr_num: '0};
      for (int s = 1; s < SPLIT_STAGES; s++) begin
         split_src[s] = split_ff[s-1];
      end
   end

   always_comb begin
      split_type    cur;
      level_type    divisor;
      div_step_type st;
      for (int s = 0; s < SPLIT_STAGES; s++) begin
         cur = split_src[s];
         // remainder of the previous division is a level number
         if (s == STAGES_PER_DIV) begin
            cur.cb_num = cur.rem[IDX_W-1:0];
            cur.rem    = '0;
         end
         if (s == 2 * STAGES_PER_DIV) begin
            cur.cr_num = cur.rem[IDX_W-1:0];
            cur.rem    = '0;
         end
         if (s < STAGES_PER_DIV) begin
            divisor = lane_levels[LANE_CB];
         end else if (s < 2 * STAGES_PER_DIV) begin
            divisor = lane_levels[LANE_CR];
         end else begin
            divisor = lane_levels[LANE_LUMA];
         end
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            st      = div_step(cur.rem, cur.shq[IDX_W-1], divisor);
            cur.rem = st.rem;
            cur.shq = {cur.shq[IDX_W-2:0], st.qbit};
         end
         split_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_vld_ff <= '0;
      end else begin
         split_vld_ff <= {split_vld_ff[SPLIT_STAGES-2:0], req_accept};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < SPLIT_STAGES; s++) begin
         split_ff[s] <= split_in[s];
      end
   end

   // ---------------- level values: n*256/R ----------------
   always_comb begin
      split_type last;
      last = split_ff[SPLIT_STAGES-1];
      lv_src[0][LANE_LUMA] = '{rem: last.rem,            quo: '0};
      lv_src[0][LANE_CR]   = '{rem: {1'b0, last.cr_num}, quo: '0};
      lv_src[0][LANE_CB]   = '{rem: {1'b0, last.cb_num}, quo: '0};
      for (int j = 1; j < LEVEL_STAGES; j++) begin
         for (int ln = 0; ln < NUM_LANES; ln++) begin
            lv_src[j][ln] = lv_ff[j-1][ln];
         end
      end
   end

   always_comb begin
      lane_div_type cur;
      div_step_type st;
      for (int j = 0; j < LEVEL_STAGES; j++) begin
         for (int ln = 0; ln < NUM_LANES; ln++) begin
            cur = lv_src[j][ln];
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
               st      = div_step(cur.rem, 1'b0, lane_levels[ln]);
               cur.rem = st.rem;
               cur.quo = {cur.quo[IDX_W-2:0], st.qbit};
            end
            lv_in[j][ln] = cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_vld_ff <= '0;
      end else begin
         lv_vld_ff <= {lv_vld_ff[LEVEL_STAGES-2:0], split_vld_ff[SPLIT_STAGES-1]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < LEVEL_STAGES; j++) begin
         for (int ln = 0; ln < NUM_LANES; ln++) begin
            lv_ff[j][ln] <= lv_in[j][ln];
         end
      end
   end

   // ---------------- color tail ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_vld_ff <= '0;
      end else begin
         tail_vld_ff <= {tail_vld_ff[TAIL_STAGES-2:0], lv_vld_ff[LEVEL_STAGES-1]};
      end
   end

   // counts of 256 and more give no half-step term
   always_comb begin
      for (int ln = 0; ln < NUM_LANES; ln++) begin
         lvl_val[ln] = lv_ff[LEVEL_STAGES-1][ln].quo +
                       (lane_levels[ln][LVL_W-1] ? '0 : half_tab[lane_levels[ln][IDX_W-1:0]]);
      end
   end

   always_comb begin
      logic signed [PROD_W-1:0] luma_s;
      luma_s = $signed({{(PROD_W - MILLI_W){1'b0}}, m_luma_ff});
      ch_sum[CH_RED]   = luma_s + m_rcb_ff;
      ch_sum[CH_GREEN] = luma_s - m_gcb_ff - m_gcr_ff;
      ch_sum[CH_BLUE]  = luma_s + m_bcr_ff;
   end

   always_comb begin
      logic [QPROD_W-1:0] prod;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         prod         = QPROD_W'(s_ff[ch].val) * QPROD_W'(RECIP_1000);
         q_val_in[ch] = prod[RECIP_SHIFT +: CH_W];
      end
   end

   always_ff @(posedge clock) begin
      // level values and centered chroma
      e_luma_ff <= lvl_val[LANE_LUMA];
      e_dcr_ff  <= LVL_W'({1'b0, lvl_val[LANE_CR]}) - CENTER_LVL;
      e_dcb_ff  <= LVL_W'({1'b0, lvl_val[LANE_CB]}) - CENTER_LVL;
      // products in thousandths
      m_luma_ff <= MILLI_W'(e_luma_ff) * SCALE_MILLI;
      m_rcb_ff  <= PROD_W'(e_dcb_ff) * COEF_R_CB;
      m_gcb_ff  <= PROD_W'(e_dcb_ff) * COEF_G_CB;
      m_gcr_ff  <= PROD_W'(e_dcr_ff) * COEF_G_CR;
      m_bcr_ff  <= PROD_W'(e_dcr_ff) * COEF_B_CR;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s_ff[ch]      <= sat_milli(ch_sum[ch]);
         q_full_ff[ch] <= s_ff[ch].full;
         q_val_ff[ch]  <= q_val_in[ch];
         if (tail_vld_ff[TAIL_STAGES-2]) begin
            rsp_ch_ff[ch] <= q_full_ff[ch] ? '1 : q_val_ff[ch];
         end
      end
   end

   assign rsp_valid = tail_vld_ff[TAIL_STAGES-1];
   assign rsp_red   = rsp_ch_ff[CH_RED];
   assign rsp_green = rsp_ch_ff[CH_GREEN];
   assign rsp_blue  = rsp_ch_ff[CH_BLUE];

endmodule

>>> sv/ycc_pcg_checker.sv
// ----------------------------------------------------------------------------
// ycc_pcg_checker
// Port-level timing checks of the palette generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "ycc_palette_color_generator_defines.svh"

module ycc_pcg_checker
   import ycc_pcg_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);

   `YCC_ASSERT_IMP(a_rsp_from_request, clock, reset, rsp_valid, $past(start && !busy, RSP_LATENCY), "result without a matching request")
   `YCC_ASSERT_DLY(a_request_answered, clock, reset, start && !busy, RSP_LATENCY, rsp_valid, "request produced no result")
   `YCC_ASSERT_NEXT(a_reset_flushes, clock, reset, !rsp_valid, "result strobe right after reset")
   `YCC_ASSERT_IMP(a_csr_blocked_busy, clock, reset, rsp_valid, !csr_ready, "register port open with a result in flight")

endmodule

bind ycc_palette_color_generator ycc_pcg_checker u_ycc_pcg_checker (.*);
